>>> rtl/tpnd_pkg.sv
`timescale 1ns / 1ps

package tpnd_pkg;

    // Field widths.
    localparam int WGT_W  = 17;
    localparam int VAL_W  = 32;
    localparam int CIDX_W = 3;

    // Long division: 8*w*m is at most 52 bits, the numerator at most 96 bits.
    localparam int DEN_W     = 52;
    localparam int NUM_W     = 96;
    localparam int DIV_STEPS = 34;
    localparam int Q_W       = DIV_STEPS + 1;
    localparam int DIV_LAT   = DIV_STEPS + 1;

    // Register stages from input to output register.
    localparam int PIPE_LAT = 2 + DIV_LAT + 5 + DIV_LAT + 1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_MU  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CV  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_DT  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SVF = 3'd3;

    localparam logic [VAL_W-1:0] CV_RESET = 32'h0001_0000;

    // One node as it travels down the pipeline.
    typedef struct packed {
        logic [2:0][VAL_W-1:0] vel_a;
        logic [2:0][VAL_W-1:0] vel_b;
        logic [DEN_W-1:0]      den_a;
        logic [DEN_W-1:0]      den_b;
        logic                  apply_force;
    } node_t;

    // Q16.16 product, truncated and saturated to 32 bits.
    function automatic logic [VAL_W-1:0] mul_q16_sat(input logic [VAL_W-1:0] a,
                                                     input logic [VAL_W-1:0] b);
        logic [2*VAL_W-1:0] p;
        p = a * b;
        return (p[2*VAL_W-1:VAL_W+16] != '0) ? '1 : p[VAL_W+15:16];
    endfunction

    // Saturate a 37-bit signed sum to the signed 32-bit range.
    function automatic logic [VAL_W-1:0] sat_s32(input logic signed [VAL_W+4:0] x);
        logic signed [VAL_W+4:0] hi;
        logic signed [VAL_W+4:0] lo;
        hi = 37'sh0_7FFF_FFFF;
        lo = -37'sh0_8000_0000;
        if (x > hi)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (x < lo)
        begin
            return 32'h8000_0000;
        end
        return x[VAL_W-1:0];
    endfunction

endpackage

>>> rtl/tpnd_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// The quotient is floor(num / den), capped at 2^DIV_STEPS.
module tpnd_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [tpnd_pkg::NUM_W-1:0]   num,
    input  logic [tpnd_pkg::DEN_W-1:0]   den,
    output logic [tpnd_pkg::Q_W-1:0]     quo
);

    logic [tpnd_pkg::DEN_W-1:0]     rem_reg [tpnd_pkg::DIV_STEPS+1];
    logic [tpnd_pkg::DEN_W-1:0]     den_reg [tpnd_pkg::DIV_STEPS+1];
    logic [tpnd_pkg::DIV_STEPS-1:0] low_reg [tpnd_pkg::DIV_STEPS+1];
    logic [tpnd_pkg::DIV_STEPS-1:0] q_reg   [tpnd_pkg::DIV_STEPS+1];
    logic                           sat_reg [tpnd_pkg::DIV_STEPS+1];

    // First stage: a high part not below den means the quotient reaches the cap.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0] <= num[tpnd_pkg::NUM_W-1:tpnd_pkg::DIV_STEPS] >=
                {{(tpnd_pkg::NUM_W-tpnd_pkg::DIV_STEPS-tpnd_pkg::DEN_W){1'b0}}, den};
            rem_reg[0] <= num[tpnd_pkg::DIV_STEPS+tpnd_pkg::DEN_W-1:tpnd_pkg::DIV_STEPS];
            low_reg[0] <= num[tpnd_pkg::DIV_STEPS-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
        end
    end

    // One trial subtraction per stage.
    for (genvar i = 1; i <= tpnd_pkg::DIV_STEPS; i++)
    begin : g_step
        logic [tpnd_pkg::DEN_W:0] trial;
        logic [tpnd_pkg::DEN_W:0] diff;
        logic                     ge;

        always_comb
        begin
            trial = {rem_reg[i-1], low_reg[i-1][tpnd_pkg::DIV_STEPS-1]};
            ge    = trial >= {1'b0, den_reg[i-1]};
            diff  = trial - {1'b0, den_reg[i-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? diff[tpnd_pkg::DEN_W-1:0] : trial[tpnd_pkg::DEN_W-1:0];
                low_reg[i] <= {low_reg[i-1][tpnd_pkg::DIV_STEPS-2:0], 1'b0};
                q_reg[i]   <= {q_reg[i-1][tpnd_pkg::DIV_STEPS-2:0], ge};
                den_reg[i] <= den_reg[i-1];
                sat_reg[i] <= sat_reg[i-1];
            end
        end
    end

    assign quo = sat_reg[tpnd_pkg::DIV_STEPS] ?
                 (tpnd_pkg::Q_W'(1) << tpnd_pkg::DIV_STEPS) :
                 {1'b0, q_reg[tpnd_pkg::DIV_STEPS]};

endmodule

>>> rtl/two_phase_nodal_drag_update.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls; the two banks of 35-stage
// long dividers (volume fractions, then the velocity increments) set the depth.
// A stalled output holds the whole pipeline; no item is lost or repeated.
// Reset clears all valid bits and loads the register defaults (cell volume 1.0).
module two_phase_nodal_drag_update (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tpnd_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [16:0]                        node_weight,
    input  logic [31:0]                        mass_a,
    input  logic [31:0]                        mass_b,
    input  logic [31:0]                        volume_a,
    input  logic [31:0]                        volume_b,
    input  logic signed [31:0]                 vel_a_x,
    input  logic signed [31:0]                 vel_a_y,
    input  logic signed [31:0]                 vel_a_z,
    input  logic signed [31:0]                 vel_b_x,
    input  logic signed [31:0]                 vel_b_y,
    input  logic signed [31:0]                 vel_b_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [31:0]                 new_vel_a_x,
    output logic signed [31:0]                 new_vel_a_y,
    output logic signed [31:0]                 new_vel_a_z,
    output logic signed [31:0]                 new_vel_b_x,
    output logic signed [31:0]                 new_vel_b_y,
    output logic signed [31:0]                 new_vel_b_z,
    output logic [1:0]                         zero_mass_flag
);

    localparam int VW = tpnd_pkg::VAL_W;
    localparam int DL = tpnd_pkg::DIV_LAT;
    localparam int PW = tpnd_pkg::DEN_W - 3 - VW;

    logic [VW-1:0] mu_reg;
    logic [VW-1:0] cv_reg;
    logic [VW-1:0] dt_reg;
    logic          svf_reg;
    logic [VW-1:0] coeff_reg;

    logic                          en;
    logic [tpnd_pkg::PIPE_LAT-1:0] vld_reg;

    logic [16:0]            s1_w_reg;
    logic [VW-1:0]          s1_ma_reg;
    logic [VW-1:0]          s1_mb_reg;
    logic [VW-1:0]          s1_va_reg;
    logic [VW-1:0]          s1_vb_reg;
    logic [2:0][VW-1:0]     s1_vel_a_reg;
    logic [2:0][VW-1:0]     s1_vel_b_reg;

    tpnd_pkg::node_t            s2_node_reg;
    logic [tpnd_pkg::DEN_W-1:0] s2_num_a_reg;
    logic [tpnd_pkg::DEN_W-1:0] s2_num_b_reg;

    tpnd_pkg::node_t          d1_reg [DL];
    logic [tpnd_pkg::Q_W-1:0] svf_qa;
    logic [tpnd_pkg::Q_W-1:0] svf_qb;
    logic [VW-1:0]            sa;
    logic [VW-1:0]            sb;

    tpnd_pkg::node_t s3_node_reg;
    logic [VW-1:0]   s3_f1_reg;
    logic [VW-1:0]   s3_sb_reg;

    tpnd_pkg::node_t s4_node_reg;
    logic [VW-1:0]   s4_factor_reg;
    logic [VW-1:0]   factor_next;

    tpnd_pkg::node_t        s5_node_reg;
    logic [2:0][2*VW-1:0]   s5_f_reg;
    logic [2:0]             s5_neg_reg;
    logic [2:0][2*VW-1:0]   f_next;
    logic [2:0]             neg_next;

    tpnd_pkg::node_t        s6_node_reg;
    logic [2:0][2*VW-1:0]   s6_plo_reg;
    logic [2:0][2*VW-1:0]   s6_phi_reg;
    logic [2:0]             s6_neg_reg;

    tpnd_pkg::node_t                 s7_node_reg;
    logic [2:0][tpnd_pkg::NUM_W-1:0] s7_num_reg;
    logic [2:0]                      s7_neg_reg;

    tpnd_pkg::node_t               d2_node_reg [DL];
    logic [2:0]                    d2_neg_reg  [DL];
    logic [2:0][tpnd_pkg::Q_W-1:0] inc_a;
    logic [2:0][tpnd_pkg::Q_W-1:0] inc_b;

    logic [2:0][VW-1:0] res_a_next;
    logic [2:0][VW-1:0] res_b_next;
    logic [1:0]         flag_next;
    logic [2:0][VW-1:0] res_a_reg;
    logic [2:0][VW-1:0] res_b_reg;
    logic [1:0]         flag_reg;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg  <= '0;
            cv_reg  <= tpnd_pkg::CV_RESET;
            dt_reg  <= '0;
            svf_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tpnd_pkg::CFG_MU:  mu_reg  <= cfg_data;
                tpnd_pkg::CFG_CV:  cv_reg  <= cfg_data;
                tpnd_pkg::CFG_DT:  dt_reg  <= cfg_data;
                tpnd_pkg::CFG_SVF: svf_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // The coefficient mu * cell volume depends on configuration only.
    always_ff @(posedge clk)
    begin
        coeff_reg <= tpnd_pkg::mul_q16_sat(cv_reg, mu_reg);
    end

    // Global stall: every stage moves when the output register can take an item.
    assign en       = !vld_reg[tpnd_pkg::PIPE_LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[tpnd_pkg::PIPE_LAT-2:0], in_valid};
        end
    end

    // Stage 1: input registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_w_reg     <= node_weight;
            s1_ma_reg    <= mass_a;
            s1_mb_reg    <= mass_b;
            s1_va_reg    <= volume_a;
            s1_vb_reg    <= volume_b;
            s1_vel_a_reg <= {vel_a_z, vel_a_y, vel_a_x};
            s1_vel_b_reg <= {vel_b_z, vel_b_y, vel_b_x};
        end
    end

    // Stage 2: weighted volumes and denominators, 8 * w * value, at full width.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_num_a_reg            <= {s1_w_reg * {{PW{1'b0}}, s1_va_reg}, 3'b000};
            s2_num_b_reg            <= {s1_w_reg * {{PW{1'b0}}, s1_vb_reg}, 3'b000};
            s2_node_reg.den_a       <= {s1_w_reg * {{PW{1'b0}}, s1_ma_reg}, 3'b000};
            s2_node_reg.den_b       <= {s1_w_reg * {{PW{1'b0}}, s1_mb_reg}, 3'b000};
            s2_node_reg.vel_a       <= s1_vel_a_reg;
            s2_node_reg.vel_b       <= s1_vel_b_reg;
            s2_node_reg.apply_force <= (s1_ma_reg != '0) && (s1_mb_reg != '0);
        end
    end

    // Volume fractions: divide by the cell volume.
    tpnd_div u_div_svf_a (
        .clk (clk),
        .en  (en),
        .num ({{(tpnd_pkg::NUM_W-tpnd_pkg::DEN_W){1'b0}}, s2_num_a_reg}),
        .den ({{(tpnd_pkg::DEN_W-VW){1'b0}}, cv_reg}),
        .quo (svf_qa)
    );

    tpnd_div u_div_svf_b (
        .clk (clk),
        .en  (en),
        .num ({{(tpnd_pkg::NUM_W-tpnd_pkg::DEN_W){1'b0}}, s2_num_b_reg}),
        .den ({{(tpnd_pkg::DEN_W-VW){1'b0}}, cv_reg}),
        .quo (svf_qb)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg[0] <= s2_node_reg;
            for (int i = 1; i < DL; i++)
            begin
                d1_reg[i] <= d1_reg[i-1];
            end
        end
    end

    assign sa = (svf_qa[tpnd_pkg::Q_W-1:VW] != '0) ? '1 : svf_qa[VW-1:0];
    assign sb = (svf_qb[tpnd_pkg::Q_W-1:VW] != '0) ? '1 : svf_qb[VW-1:0];

    // Stage 3: coeff * svf_a.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_node_reg <= d1_reg[DL-1];
            s3_f1_reg   <= tpnd_pkg::mul_q16_sat(coeff_reg, sa);
            s3_sb_reg   <= sb;
        end
    end

    // Stage 4: drag factor for the selected model.
    always_comb
    begin
        if (svf_reg)
        begin
            factor_next = tpnd_pkg::mul_q16_sat(s3_f1_reg, s3_sb_reg);
        end
        else if (s3_node_reg.apply_force)
        begin
            factor_next = coeff_reg;
        end
        else
        begin
            factor_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_node_reg   <= s3_node_reg;
            s4_factor_reg <= factor_next;
        end
    end

    // Stage 5: force magnitude, factor * |v_b - v_a|.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [VW:0] dv;
            logic [VW:0] mag;
            logic [2*VW:0] prod;
            dv   = {s4_node_reg.vel_b[k][VW-1], s4_node_reg.vel_b[k]} -
                   {s4_node_reg.vel_a[k][VW-1], s4_node_reg.vel_a[k]};
            mag  = dv[VW] ? (~dv + 1'b1) : dv;
            prod = s4_factor_reg * mag;
            neg_next[k] = dv[VW];
            f_next[k]   = prod[2*VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_node_reg <= s4_node_reg;
            s5_f_reg    <= f_next;
            s5_neg_reg  <= neg_next;
        end
    end

    // Stage 6: force * time step as two partial products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_node_reg <= s5_node_reg;
            s6_neg_reg  <= s5_neg_reg;
            for (int k = 0; k < 3; k++)
            begin
                s6_plo_reg[k] <= s5_f_reg[k][VW-1:0] * dt_reg;
                s6_phi_reg[k] <= s5_f_reg[k][2*VW-1:VW] * dt_reg;
            end
        end
    end

    // Stage 7: join the partial products into the 96-bit numerator.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_node_reg <= s6_node_reg;
            s7_neg_reg  <= s6_neg_reg;
            for (int k = 0; k < 3; k++)
            begin
                s7_num_reg[k] <= {{VW{1'b0}}, s6_plo_reg[k]} + {s6_phi_reg[k], {VW{1'b0}}};
            end
        end
    end

    // Velocity increments: numerator over each material's denominator.
    for (genvar k = 0; k < 3; k++)
    begin : g_inc
        tpnd_div u_div_a (
            .clk (clk),
            .en  (en),
            .num (s7_num_reg[k]),
            .den (s7_node_reg.den_a),
            .quo (inc_a[k])
        );

        tpnd_div u_div_b (
            .clk (clk),
            .en  (en),
            .num (s7_num_reg[k]),
            .den (s7_node_reg.den_b),
            .quo (inc_b[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_node_reg[0] <= s7_node_reg;
            d2_neg_reg[0]  <= s7_neg_reg;
            for (int i = 1; i < DL; i++)
            begin
                d2_node_reg[i] <= d2_node_reg[i-1];
                d2_neg_reg[i]  <= d2_neg_reg[i-1];
            end
        end
    end

    // Final stage: apply opposite-signed increments, or keep the velocity of a zero-mass material.
    always_comb
    begin
        tpnd_pkg::node_t nd;
        logic [2:0]      ng;
        nd = d2_node_reg[DL-1];
        ng = d2_neg_reg[DL-1];
        flag_next[0] = (nd.den_a == '0);
        flag_next[1] = (nd.den_b == '0);
        for (int k = 0; k < 3; k++)
        begin
            logic signed [VW+4:0] va_x;
            logic signed [VW+4:0] vb_x;
            logic signed [VW+4:0] ia_x;
            logic signed [VW+4:0] ib_x;
            va_x = {{5{nd.vel_a[k][VW-1]}}, nd.vel_a[k]};
            vb_x = {{5{nd.vel_b[k][VW-1]}}, nd.vel_b[k]};
            ia_x = {2'b00, inc_a[k]};
            ib_x = {2'b00, inc_b[k]};
            if (flag_next[0])
            begin
                res_a_next[k] = nd.vel_a[k];
            end
            else
            begin
                res_a_next[k] = tpnd_pkg::sat_s32(ng[k] ? va_x - ia_x : va_x + ia_x);
            end
            if (flag_next[1])
            begin
                res_b_next[k] = nd.vel_b[k];
            end
            else
            begin
                res_b_next[k] = tpnd_pkg::sat_s32(ng[k] ? vb_x + ib_x : vb_x - ib_x);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_a_reg <= res_a_next;
            res_b_reg <= res_b_next;
            flag_reg  <= flag_next;
        end
    end

    assign out_valid      = vld_reg[tpnd_pkg::PIPE_LAT-1];
    assign new_vel_a_x    = res_a_reg[0];
    assign new_vel_a_y    = res_a_reg[1];
    assign new_vel_a_z    = res_a_reg[2];
    assign new_vel_b_x    = res_b_reg[0];
    assign new_vel_b_y    = res_b_reg[1];
    assign new_vel_b_z    = res_b_reg[2];
    assign zero_mass_flag = flag_reg;

endmodule

>>> rtl/tpnd_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the drag update block.
module tpnd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] new_vel_a_x,
    input logic [1:0]  zero_mass_flag
);

    // A result waiting at the output holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_vel_a_x)
            && $stable(zero_mass_flag))
        else $error("stalled result changed");

    // A stalled output stops the pipeline, so no new item is taken.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item accepted during output stall");

    // With nothing waiting at the output, the block always takes an item.
    a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind two_phase_nodal_drag_update tpnd_checker u_tpnd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .new_vel_a_x    (new_vel_a_x),
    .zero_mass_flag (zero_mass_flag)
);
